@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the tokenizer RTL.
// Included by every module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop at every rising edge, held off while reset is low.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that cons holds in the cycle after ante, held off while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/gtn_pkg.sv @@
// Shared types, token codes, character constants and character classes
// for the grammar notation tokenizer. No dependencies.
`timescale 1ns / 1ps

package gtn_pkg;

    localparam int LINE_W         = 16;
    localparam int NAME_LIMIT_DEF = 256;
    localparam int QDEPTH         = 4;

    // token kinds
    localparam logic [3:0] KIND_NEWLINE    = 4'd0;
    localparam logic [3:0] KIND_NAME       = 4'd1;
    localparam logic [3:0] KIND_EQUALS     = 4'd2;
    localparam logic [3:0] KIND_BAR        = 4'd3;
    localparam logic [3:0] KIND_COMMA      = 4'd4;
    localparam logic [3:0] KIND_LPAREN     = 4'd5;
    localparam logic [3:0] KIND_RPAREN     = 4'd6;
    localparam logic [3:0] KIND_LBRACE     = 4'd7;
    localparam logic [3:0] KIND_RBRACE     = 4'd8;
    localparam logic [3:0] KIND_SEMI       = 4'd9;
    localparam logic [3:0] KIND_QUOTED     = 4'd10;
    localparam logic [3:0] KIND_OTHER      = 4'd11;
    localparam logic [3:0] KIND_END        = 4'd12;
    localparam logic [3:0] KIND_DISCARD    = 4'd13;
    localparam logic [3:0] KIND_OPEN_CMT   = 4'd14;
    localparam logic [3:0] KIND_MISS_QUOTE = 4'd15;

    // characters
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // one result item without its line number
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] lex;
        logic       empty;
        logic       last;
    } t_res;

    // all results caused by one input item
    typedef struct packed {
        logic [1:0]        cnt;
        t_res [2:0]        res;
        logic [LINE_W-1:0] line;
    } t_bundle;

    function automatic t_res mk_res(logic [3:0] kind, logic [7:0] lex,
                                    logic empty, logic last);
        t_res r;
        r.kind  = kind;
        r.lex   = empty ? 8'h00 : lex;
        r.empty = empty;
        r.last  = last;
        return r;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_name_char(logic [7:0] c);
        return is_alpha(c) || ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_USCORE);
    endfunction

endpackage

@@ rtl/core/gtn_front.sv @@
// Front end: lexer state, classifies each byte and builds its result bundle.
// Depends on gtn_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gtn_front #(
    parameter int NAME_LIMIT = gtn_pkg::NAME_LIMIT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_op,
    input  logic [7:0]      i_ch,
    output logic            o_push,
    output gtn_pkg::t_bundle o_bundle
);
    import gtn_pkg::*;

    localparam int LenW = $clog2(NAME_LIMIT);
    localparam logic [LenW-1:0] LenMax = LenW'(NAME_LIMIT - 1);

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_WS      = 3'd1;
    localparam logic [2:0] M_NAME    = 3'd2;
    localparam logic [2:0] M_PAREN   = 3'd3;
    localparam logic [2:0] M_COMMENT = 3'd4;
    localparam logic [2:0] M_CSTAR   = 3'd5;
    localparam logic [2:0] M_QUOTE1  = 3'd6;
    localparam logic [2:0] M_QUOTE2  = 3'd7;

    logic [2:0]        r_mode, n_mode;
    logic [7:0]        r_held, n_held;
    logic [LenW-1:0]   r_len, n_len;
    logic [7:0]        r_qc, n_qc;
    logic              r_qdbl, n_qdbl;
    logic [LINE_W-1:0] r_line, n_line;

    logic       pre_v;
    t_res       pre_r;
    logic       run_idle;
    logic [1:0] t_n;
    t_res       t0, t1;
    logic [7:0] q;
    t_bundle    bnd;

    always_comb begin
        n_mode   = r_mode;
        n_held   = r_held;
        n_len    = r_len;
        n_qc     = r_qc;
        n_qdbl   = r_qdbl;
        pre_v    = 1'b0;
        pre_r    = '0;
        run_idle = 1'b0;
        t_n      = 2'd0;
        t0       = '0;
        t1       = '0;
        q        = r_qdbl ? CH_DQUOTE : CH_SQUOTE;

        if (i_op) begin
            // end of text: flush the pending construct, then the end token
            case (r_mode)
                M_NAME: begin
                    pre_v = 1'b1;
                    pre_r = mk_res(KIND_NAME, r_held, 1'b0, 1'b1);
                end
                M_PAREN: begin
                    pre_v = 1'b1;
                    pre_r = mk_res(KIND_LPAREN, CH_LPAR, 1'b0, 1'b1);
                end
                M_COMMENT, M_CSTAR: begin
                    pre_v = 1'b1;
                    pre_r = mk_res(KIND_OPEN_CMT, 8'h00, 1'b1, 1'b1);
                end
                M_QUOTE1, M_QUOTE2: begin
                    pre_v = 1'b1;
                    pre_r = mk_res(KIND_MISS_QUOTE, 8'h00, 1'b1, 1'b1);
                end
                default: begin
                    pre_v = 1'b0;
                end
            endcase
            t_n    = 2'd1;
            t0     = mk_res(KIND_END, 8'h00, 1'b1, 1'b1);
            n_mode = M_IDLE;
            n_len  = '0;
            n_qdbl = 1'b0;
        end else begin
            case (r_mode)
                M_WS: begin
                    run_idle = !is_space(i_ch);
                end
                M_NAME: begin
                    if (is_name_char(i_ch)) begin
                        if (r_len >= LenMax) begin
                            pre_v    = 1'b1;
                            pre_r    = mk_res(KIND_DISCARD, 8'h00, 1'b1, 1'b1);
                            n_len    = '0;
                            run_idle = 1'b1;
                        end else begin
                            pre_v  = 1'b1;
                            pre_r  = mk_res(KIND_NAME, r_held, 1'b0, 1'b0);
                            n_held = i_ch;
                            n_len  = r_len + LenW'(1);
                        end
                    end else begin
                        pre_v    = 1'b1;
                        pre_r    = mk_res(KIND_NAME, r_held, 1'b0, 1'b1);
                        n_len    = '0;
                        run_idle = 1'b1;
                    end
                end
                M_PAREN: begin
                    if (i_ch == CH_STAR) begin
                        n_mode = M_COMMENT;
                    end else begin
                        pre_v    = 1'b1;
                        pre_r    = mk_res(KIND_LPAREN, CH_LPAR, 1'b0, 1'b1);
                        run_idle = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (i_ch == CH_STAR) begin
                        n_mode = M_CSTAR;
                    end
                end
                M_CSTAR: begin
                    if (i_ch == CH_RPAR) begin
                        n_mode = M_IDLE;
                    end else if (i_ch != CH_STAR) begin
                        n_mode = M_COMMENT;
                    end
                end
                M_QUOTE1: begin
                    if (i_ch == q) begin
                        pre_v  = 1'b1;
                        pre_r  = mk_res(KIND_QUOTED, 8'h00, 1'b1, 1'b1);
                        n_mode = M_IDLE;
                    end else begin
                        n_qc   = i_ch;
                        n_mode = M_QUOTE2;
                    end
                end
                M_QUOTE2: begin
                    if (i_ch == q) begin
                        pre_v  = 1'b1;
                        pre_r  = mk_res(KIND_QUOTED, r_qc, 1'b0, 1'b1);
                        n_mode = M_IDLE;
                    end else begin
                        pre_v    = 1'b1;
                        pre_r    = mk_res(KIND_MISS_QUOTE, 8'h00, 1'b1, 1'b1);
                        run_idle = 1'b1;
                    end
                end
                default: begin
                    run_idle = 1'b1;
                end
            endcase

            // start a new construct with the current byte
            if (run_idle) begin
                n_mode = M_IDLE;
                if (i_ch == CH_LF) begin
                    t_n = 2'd2;
                    t0  = mk_res(KIND_NEWLINE, CH_BSLASH, 1'b0, 1'b0);
                    t1  = mk_res(KIND_NEWLINE, CH_LOW_N, 1'b0, 1'b1);
                end else if (is_space(i_ch)) begin
                    n_mode = M_WS;
                end else if (is_alpha(i_ch) || (i_ch == CH_USCORE)) begin
                    n_mode = M_NAME;
                    n_held = i_ch;
                    n_len  = LenW'(1);
                end else begin
                    t_n = 2'd1;
                    case (i_ch)
                        CH_EQ:     t0 = mk_res(KIND_EQUALS, i_ch, 1'b0, 1'b1);
                        CH_BAR:    t0 = mk_res(KIND_BAR, i_ch, 1'b0, 1'b1);
                        CH_COMMA:  t0 = mk_res(KIND_COMMA, i_ch, 1'b0, 1'b1);
                        CH_RPAR:   t0 = mk_res(KIND_RPAREN, i_ch, 1'b0, 1'b1);
                        CH_LBRACE: t0 = mk_res(KIND_LBRACE, i_ch, 1'b0, 1'b1);
                        CH_RBRACE: t0 = mk_res(KIND_RBRACE, i_ch, 1'b0, 1'b1);
                        CH_SEMI:   t0 = mk_res(KIND_SEMI, i_ch, 1'b0, 1'b1);
                        CH_LPAR: begin
                            t_n    = 2'd0;
                            n_mode = M_PAREN;
                        end
                        CH_SQUOTE: begin
                            t_n    = 2'd0;
                            n_mode = M_QUOTE1;
                            n_qdbl = 1'b0;
                        end
                        CH_DQUOTE: begin
                            t_n    = 2'd0;
                            n_mode = M_QUOTE1;
                            n_qdbl = 1'b1;
                        end
                        default:   t0 = mk_res(KIND_OTHER, i_ch, 1'b0, 1'b1);
                    endcase
                end
            end
        end

        if (i_op) begin
            n_line = LINE_W'(1);
        end else if ((i_ch == CH_LF) && (r_line != {LINE_W{1'b1}})) begin
            n_line = r_line + LINE_W'(1);
        end else begin
            n_line = r_line;
        end

        // pack the leading result ahead of the trailing ones
        bnd.line = r_line;
        if (pre_v) begin
            bnd.cnt    = t_n + 2'd1;
            bnd.res[0] = pre_r;
            bnd.res[1] = t0;
            bnd.res[2] = t1;
        end else begin
            bnd.cnt    = t_n;
            bnd.res[0] = t0;
            bnd.res[1] = t1;
            bnd.res[2] = '0;
        end
    end

    assign o_push   = i_valid && (bnd.cnt != 2'd0);
    assign o_bundle = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_len  <= '0;
            r_qdbl <= 1'b0;
            r_line <= LINE_W'(1);
        end else if (i_valid) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_qdbl <= n_qdbl;
            r_line <= n_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_held <= n_held;
            r_qc   <= n_qc;
        end
    end

    `ASSERT_RST(a_name_len, i_clk, i_rst_n, (r_mode == M_NAME) |-> (r_len != '0), "name mode with zero length")
    `ASSERT_NEXT(a_end_reset, i_clk, i_rst_n, i_valid && i_op, (r_line == LINE_W'(1)) && (r_mode == M_IDLE), "end of text did not restart state")

endmodule

@@ rtl/core/gtn_queue.sv @@
// Short bundle queue between the front and back ends.
// Depends on gtn_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gtn_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gtn_pkg::t_bundle i_data,
    output logic             o_full,
    input  logic             i_pop,
    output gtn_pkg::t_bundle o_data,
    output logic             o_empty
);
    import gtn_pkg::*;

    localparam int PtrW = $clog2(QDEPTH);
    localparam int CntW = $clog2(QDEPTH + 1);

    t_bundle         r_mem [QDEPTH];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CntW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PtrW'(QDEPTH - 1)) ? '0 : r_wr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrW'(QDEPTH - 1)) ? '0 : r_rd + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `ASSERT_RST(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CntW'(QDEPTH), "queue count past depth")
    `ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, do_push && !do_pop, r_cnt == $past(r_cnt) + CntW'(1), "queue count did not advance on push")

endmodule

@@ rtl/core/gtn_back.sv @@
// Back end: holds one bundle and hands its results out one transfer at a time.
// Depends on gtn_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gtn_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_empty,
    input  gtn_pkg::t_bundle          i_q_data,
    output logic                      o_q_pop,
    input  logic                      i_pop,
    output logic                      o_empty,
    output gtn_pkg::t_res             o_res,
    output logic [gtn_pkg::LINE_W-1:0] o_line
);
    import gtn_pkg::*;

    logic       r_valid;
    t_bundle    r_bundle;
    logic [1:0] r_idx;
    logic       at_last;
    logic       take;

    assign at_last = (r_idx == (r_bundle.cnt - 2'd1));
    // load the next bundle when empty or when the last result leaves
    assign take    = !i_q_empty && (!r_valid || (i_pop && at_last));
    assign o_q_pop = take;
    assign o_empty = !r_valid;
    assign o_res   = r_bundle.res[r_idx];
    assign o_line  = r_bundle.line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (take) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (i_pop && r_valid) begin
            if (at_last) begin
                r_valid <= 1'b0;
                r_idx   <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_bundle <= i_q_data;
        end
    end

    `ASSERT_RST(a_idx_range, i_clk, i_rst_n, r_valid |-> (r_idx < r_bundle.cnt), "result index past bundle count")
    `ASSERT_NEXT(a_mid_hold, i_clk, i_rst_n, i_pop && r_valid && !at_last, r_valid, "bundle dropped before its last result")

endmodule

@@ rtl/core/grammar_notation_tokenizer.sv @@
// Top level of the grammar notation tokenizer: front end, bundle queue, back end.
// Depends on gtn_pkg, gtn_front, gtn_queue and gtn_back.
`timescale 1ns / 1ps

// Grammar text goes in one byte per transfer (op = 0), with op = 1 marking the
// end of a text; tokens come out as a queue of result items, one lexeme
// character per item, last = 1 on the final item of each token. A byte is
// accepted in every cycle while full is low; each byte yields zero to three
// result items, which the back end delivers one per cycle while pop is high,
// so the sustained rate is one byte per cycle as long as the output side takes
// about one result per byte. The lexer state advances once per byte in the front
// end; its results wait in a four-entry bundle queue, and full rises only when
// that queue is full. A byte's first result passes through the queue and the
// back-end bundle register. Names stream out with one character held
// back, so a name's last character leaves with the byte that follows it.
// Comments (* *) produce nothing; error items (discard of an overlong name,
// unclosed comment, missing quote) carry the line number, which saturates at
// 65535 and restarts at one after each end of text.
module grammar_notation_tokenizer #(
    parameter int NAME_LIMIT = gtn_pkg::NAME_LIMIT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       i_op,
    input  logic [7:0]                 i_ch,
    output logic                       empty,
    input  logic                       pop,
    output logic [3:0]                 o_kind,
    output logic [7:0]                 o_lexeme_char,
    output logic                       o_empty_res,
    output logic                       o_last,
    output logic [gtn_pkg::LINE_W-1:0] o_line
);
    import gtn_pkg::*;

    logic    in_xfer;
    logic    f_push;
    t_bundle f_bundle;
    logic    q_empty;
    t_bundle q_data;
    logic    q_pop;
    t_res    cur;

    // accept a byte whenever the queue has room
    assign in_xfer = push && !full;

    gtn_front #(
        .NAME_LIMIT(NAME_LIMIT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_xfer),
        .i_op     (i_op),
        .i_ch     (i_ch),
        .o_push   (f_push),
        .o_bundle (f_bundle)
    );

    // bytes with no result never enter the queue
    gtn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_bundle),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    gtn_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (cur),
        .o_line    (o_line)
    );

    assign o_kind        = cur.kind;
    assign o_lexeme_char = cur.lex;
    assign o_empty_res   = cur.empty;
    assign o_last        = cur.last;

endmodule
